[design/pbra_pkg.sv]
// ----------------------------------------------------------------------------
// pbra_pkg
// Shared types and constants of the paged bitmap run allocator.
// ----------------------------------------------------------------------------
package pbra_pkg;

  localparam int NUM_PAGES_DEF       = 16;
  localparam int BLOCKS_PER_PAGE_DEF = 64;

  localparam logic [1:0] ST_OK           = 2'd0;
  localparam logic [1:0] ST_EXHAUSTED    = 2'd1;
  localparam logic [1:0] ST_BAD_COUNT    = 2'd2;
  localparam logic [1:0] ST_UNKNOWN_PAGE = 2'd3;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  typedef struct packed {
    logic       op;
    logic [6:0] block_count;
    logic [3:0] page_index;
    logic [5:0] block_offset;
  } req_t;

  typedef struct packed {
    logic [1:0] status;
    logic [3:0] granted_page;
    logic [5:0] granted_offset;
    logic [6:0] granted_count;
  } rsp_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_SCAN,
    S_DONE
  } state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;      // capture request
    logic scan;      // start the walk at the newest page in use
    logic step;      // move to next lower page
    logic commit;    // write map / finish
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic precheck_done; // request is a failure or a free, result decided
    logic hit;           // current page holds a fitting run
    logic last_page;     // current page is page 0 or none in use
  } sts_t;

endpackage

[design/pbra_datapath.sv]
// ----------------------------------------------------------------------------
// pbra_datapath
// Page map store, first-fit run search over one page per cycle, result build.
// ----------------------------------------------------------------------------
module pbra_datapath #(
  parameter int NUM_PAGES       = pbra_pkg::NUM_PAGES_DEF,
  parameter int BLOCKS_PER_PAGE = pbra_pkg::BLOCKS_PER_PAGE_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  pbra_pkg::req_t req,
  input  pbra_pkg::cmd_t cmd,
  output pbra_pkg::sts_t sts,
  output pbra_pkg::rsp_t rsp
);

  localparam int PW = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1;
  localparam int CW = $clog2(NUM_PAGES + 1);
  localparam int BPP = BLOCKS_PER_PAGE;

  logic [BPP-1:0] maps [NUM_PAGES];
  logic [NUM_PAGES-1:0] map_valid;
  logic [CW-1:0] pages_in_use;

  pbra_pkg::req_t r;
  pbra_pkg::rsp_t rsp_next;
  logic [CW-1:0]  cur;        // index plus one of the page under search, 0 for none
  logic [BPP-1:0] cur_map;
  logic [1:0]     pre_status;
  logic           pre_fail;
  logic           is_free;
  logic [BPP-1:0] run;
  logic [6:0]     found_off;
  logic           found;
  logic [PW-1:0]  cur_idx;

  // Mask of count low bits
  always_comb begin
    run = '0;
    for (int i = 0; i < BPP; i++) begin
      if (7'(i) < r.block_count) run[i] = 1'b1;
    end
  end

  assign cur_idx = PW'(cur - CW'(1));
  assign cur_map = map_valid[cur_idx] ? maps[cur_idx] : '0;

  // First-fit search of the current page
  always_comb begin
    found = 1'b0;
    found_off = '0;
    for (int o = BPP - 1; o >= 0; o--) begin
      if ((8'(o) + 8'(r.block_count) <= 8'(BPP)) && ((cur_map & (run << o)) == '0)) begin
        found = 1'b1;
        found_off = 7'(o);
      end
    end
  end

  // Early outcome of the request checks
  always_comb begin
    pre_fail = 1'b0;
    pre_status = pbra_pkg::ST_OK;
    is_free = (r.op == pbra_pkg::OP_FREE);
    if (is_free) begin
      if ({4'b0, r.page_index} >= 8'(pages_in_use) || 32'(r.page_index) >= NUM_PAGES) begin
        pre_fail = 1'b1;
        pre_status = pbra_pkg::ST_UNKNOWN_PAGE;
      end else if (r.block_count == '0 ||
                   8'(r.block_offset) + 8'(r.block_count) > 8'(BPP)) begin
        pre_fail = 1'b1;
        pre_status = pbra_pkg::ST_BAD_COUNT;
      end
    end else if (r.block_count == '0 || 8'(r.block_count) > 8'(BPP)) begin
      pre_fail = 1'b1;
      pre_status = pbra_pkg::ST_BAD_COUNT;
    end
  end

  assign sts.precheck_done = pre_fail || is_free;
  assign sts.hit = (cur != '0) && found;
  assign sts.last_page = (cur <= CW'(1));

  // Build the result beat of the item under commit
  always_comb begin
    rsp_next = '0;
    if (pre_fail) begin
      rsp_next.status = pre_status;
    end else if (is_free) begin
      rsp_next.granted_page = r.page_index;
      rsp_next.granted_offset = r.block_offset;
      rsp_next.granted_count = r.block_count;
    end else if (sts.hit) begin
      rsp_next.granted_page = 4'(cur_idx);
      rsp_next.granted_offset = found_off[5:0];
      rsp_next.granted_count = r.block_count;
    end else if (32'(pages_in_use) >= NUM_PAGES) begin
      rsp_next.status = pbra_pkg::ST_EXHAUSTED;
    end else begin
      rsp_next.granted_page = 4'(pages_in_use);
      rsp_next.granted_count = r.block_count;
    end
  end

  // Capture request, walk pages, update maps, hold result
  always_ff @(posedge clk) begin
    if (rst) begin
      map_valid <= '0;
      pages_in_use <= '0;
    end else if (cmd.load) begin
      r <= req;
    end else if (cmd.scan) begin
      cur <= pages_in_use;
    end else if (cmd.step) begin
      cur <= cur - CW'(1);
    end else if (cmd.commit) begin
      rsp <= rsp_next;
      if (!pre_fail) begin
        if (is_free) begin
          maps[PW'(r.page_index)] <= cur_map & ~(run << r.block_offset);
        end else if (sts.hit) begin
          maps[cur_idx] <= cur_map | (run << found_off);
          map_valid[cur_idx] <= 1'b1;
        end else if (32'(pages_in_use) < NUM_PAGES) begin
          maps[PW'(pages_in_use)] <= run;
          map_valid[PW'(pages_in_use)] <= 1'b1;
          pages_in_use <= pages_in_use + CW'(1);
        end
      end
    end
    if (cmd.load && !rst) begin
      // point at the named page so a free reads its map
      cur <= CW'(req.page_index) + CW'(1);
    end
  end

endmodule

[design/pbra_ctrl.sv]
// ----------------------------------------------------------------------------
// pbra_ctrl
// Sequencer: capture, check, page walk newest first, commit, hand off result.
// ----------------------------------------------------------------------------
module pbra_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  input  pbra_pkg::sts_t sts,
  output pbra_pkg::cmd_t cmd
);

  pbra_pkg::state_t state, state_next;

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      pbra_pkg::S_IDLE:  if (in_valid) state_next = pbra_pkg::S_CHECK;
      pbra_pkg::S_CHECK: state_next = sts.precheck_done ? pbra_pkg::S_DONE : pbra_pkg::S_SCAN;
      pbra_pkg::S_SCAN:  if (sts.hit || sts.last_page) state_next = pbra_pkg::S_DONE;
      pbra_pkg::S_DONE:  if (out_ready) state_next = pbra_pkg::S_IDLE;
      default:           state_next = pbra_pkg::S_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd = '0;
    in_ready = 1'b0;
    out_valid = 1'b0;
    unique case (state)
      pbra_pkg::S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      pbra_pkg::S_CHECK: begin
        cmd.commit = sts.precheck_done;
        cmd.scan = !sts.precheck_done;
      end
      pbra_pkg::S_SCAN: begin
        cmd.commit = sts.hit || sts.last_page;
        cmd.step = !(sts.hit || sts.last_page);
      end
      pbra_pkg::S_DONE: out_valid = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= pbra_pkg::S_IDLE;
    else     state <= state_next;
  end

endmodule

[design/paged_bitmap_run_allocator_top.sv]
// ----------------------------------------------------------------------------
// paged_bitmap_run_allocator_top
// First-fit contiguous block allocator over a pool of bitmap pages.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready/in_data) carries allocate or free beats;
// output channel (out_valid/out_ready/out_data) returns one result beat each.
// One item is worked at a time. A free or a rejected request is committed in
// the check state and raises its result from the done state. An allocate
// walks the pages in use newest first, one page per cycle through a single
// first-fit search unit, and commits on the page that fits, on page 0, or at
// once when no page is in use. A new page is brought in on the commit cycle
// when no page fits and the pool has room; else the status is exhausted.
// The result stays valid while the receiver stalls; no new beat is taken
// until it is delivered. Synchronous reset empties the pool: no page in use
// and every map reads free, with no clearing pass.
// ----------------------------------------------------------------------------
module paged_bitmap_run_allocator_top #(
  parameter int NUM_PAGES       = pbra_pkg::NUM_PAGES_DEF,
  parameter int BLOCKS_PER_PAGE = pbra_pkg::BLOCKS_PER_PAGE_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  pbra_pkg::req_t in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output pbra_pkg::rsp_t out_data
);

  pbra_pkg::cmd_t cmd;
  pbra_pkg::sts_t sts;

  pbra_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready),
    .sts(sts), .cmd(cmd)
  );

  pbra_datapath #(.NUM_PAGES(NUM_PAGES), .BLOCKS_PER_PAGE(BLOCKS_PER_PAGE)) u_dp (
    .clk(clk), .rst(rst), .req(in_data), .cmd(cmd), .sts(sts), .rsp(out_data)
  );

endmodule
